### rtl/dfir_pkg.sv
// dfir_pkg: shared constants and codes for the decimating FIR filter.
// No dependencies; used by the interfaces and by decimating_fir_filter.
`timescale 1ns / 1ps

package dfir_pkg;

  // default sizing
  localparam int unsigned MaxTapsDefault     = 256;
  localparam int unsigned SampleWidthDefault = 16;
  localparam int unsigned CoefWidthDefault   = 16;

  // register file
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;
  localparam int unsigned DecWidth   = 5;
  localparam int unsigned TapsWidth  = 9;
  localparam int unsigned PhaseWidth = 4;
  localparam int unsigned IndexWidth = 8;

  localparam logic [DecWidth-1:0]  DecReset  = DecWidth'(10);
  localparam logic [TapsWidth-1:0] TapsReset = TapsWidth'(151);
  localparam logic [DecWidth-1:0]  DecMax    = DecWidth'(16);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DECIMATION = 1'b0,
    REG_TAPS       = 1'b1
  } reg_idx_e;

  // item kind
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

endpackage

### rtl/dfir_in_if.sv
// dfir_in_if: input channel of the FIR filter (samples and coefficient writes).
// Depends on dfir_pkg for default widths.
`timescale 1ns / 1ps

interface dfir_in_if #(
  parameter int unsigned SAMPLE_WIDTH = dfir_pkg::SampleWidthDefault,
  parameter int unsigned COEF_WIDTH   = dfir_pkg::CoefWidthDefault
);
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic signed [SAMPLE_WIDTH-1:0]     sample;
  logic [dfir_pkg::IndexWidth-1:0]    coef_index;
  logic signed [COEF_WIDTH-1:0]       coef_value;

  modport source (output valid, func, sample, coef_index, coef_value, input ready);
  modport sink (input valid, func, sample, coef_index, coef_value, output ready);
endinterface

### rtl/dfir_out_if.sv
// dfir_out_if: result channel of the FIR filter.
// Depends on dfir_pkg for default widths.
`timescale 1ns / 1ps

interface dfir_out_if #(
  parameter int unsigned SAMPLE_WIDTH = dfir_pkg::SampleWidthDefault
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink (input valid, filtered, saturated, output ready);
endinterface

### rtl/dfir_ram.sv
// dfir_ram: generic simple dual-port ram, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dfir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/decimating_fir_filter.sv
// decimating_fir_filter: decimating FIR filter with programmable coefficients.
// Depends on dfir_pkg, dfir_in_if, dfir_out_if and dfir_ram.
`timescale 1ns / 1ps

// Samples and coefficients are Q1.(SAMPLE_WIDTH-1) and Q1.(COEF_WIDTH-1). A coefficient write
// transfer and a sample that produces no output leave the block idle. A sample that produces
// an output (the first after reset, then one every `decimation` samples) holds off the next
// transfer while the block runs one multiply-accumulate per tap, paced by the single read
// port of the coefficient ram and the delay-line ram and the one shared multiplier, then
// drains the pipeline, rounds and saturates. Saturation waits longer while the previous output
// still sits unaccepted in the result register.
// The delay line is a circular buffer in ram; a fill count makes taps never written read as
// zero, so there is no clearing pass after reset. The result register lets the next transfer
// in while a finished output waits. Write configuration only while the block is idle.
module decimating_fir_filter #(
  parameter int unsigned MAX_TAPS     = dfir_pkg::MaxTapsDefault,
  parameter int unsigned SAMPLE_WIDTH = dfir_pkg::SampleWidthDefault,
  parameter int unsigned COEF_WIDTH   = dfir_pkg::CoefWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dfir_in_if.sink                           in_i,
  dfir_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dfir_pkg::PaddrWidth-1:0]   paddr,
  input  logic [dfir_pkg::PdataWidth-1:0]   pwdata,
  output logic [dfir_pkg::PdataWidth-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned TCW   = $clog2(MAX_TAPS + 1);
  localparam int unsigned PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned ACC_W = PW + AW;
  localparam int unsigned RW    = ACC_W + 1;
  localparam logic [AW-1:0]  LastAddr = AW'(MAX_TAPS - 1);
  localparam logic [TCW-1:0] FillMax  = TCW'(MAX_TAPS);
  localparam logic signed [RW-1:0] RoundHalf = RW'(1 << (COEF_WIDTH - 2));
  localparam logic signed [RW-1:0] SatHi     = RW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] SatLo     = -RW'(1 << (SAMPLE_WIDTH - 1));

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_WAIT  = 5'b00100,
    S_ROUND = 5'b01000,
    S_SAT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [dfir_pkg::DecWidth-1:0]  dec_q;
  logic [dfir_pkg::TapsWidth-1:0] taps_q;
  logic                           cfg_wr;
  dfir_pkg::reg_idx_e             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dfir_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q  <= dfir_pkg::DecReset;
      taps_q <= dfir_pkg::TapsReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dfir_pkg::REG_DECIMATION: dec_q  <= pwdata[dfir_pkg::DecWidth-1:0];
        dfir_pkg::REG_TAPS:       taps_q <= pwdata[dfir_pkg::TapsWidth-1:0];
        default:                  dec_q  <= dec_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dfir_pkg::REG_DECIMATION: prdata = dfir_pkg::PdataWidth'(dec_q);
      dfir_pkg::REG_TAPS:       prdata = dfir_pkg::PdataWidth'(taps_q);
      default:                  prdata = '0;
    endcase
  end

  // clamped settings
  logic [dfir_pkg::DecWidth-1:0] dec_eff;
  logic [TCW-1:0]                taps_eff;
  logic [31:0]                   taps_ext;

  assign taps_ext = 32'(taps_q);

  always_comb begin
    priority if (dec_q == '0) begin
      dec_eff = dfir_pkg::DecWidth'(1);
    end else if (dec_q > dfir_pkg::DecMax) begin
      dec_eff = dfir_pkg::DecMax;
    end else begin
      dec_eff = dec_q;
    end
    priority if (taps_ext == 32'd0) begin
      taps_eff = TCW'(1);
    end else if (taps_ext > 32'(MAX_TAPS)) begin
      taps_eff = FillMax;
    end else begin
      taps_eff = TCW'(taps_ext);
    end
  end

  // input transfer
  logic in_acc, is_sample, is_coef, coef_in_range;
  logic [31:0] idx_ext;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign is_sample     = in_acc && (dfir_pkg::func_e'(in_i.func) == dfir_pkg::FUNC_SAMPLE);
  assign is_coef       = in_acc && (dfir_pkg::func_e'(in_i.func) == dfir_pkg::FUNC_COEF);
  assign idx_ext       = 32'(in_i.coef_index);
  assign coef_in_range = idx_ext < 32'(MAX_TAPS);

  // sequencing state
  logic [dfir_pkg::PhaseWidth-1:0] phase_q, phase_d;
  logic [AW-1:0]  wp_q, wp_d, rp_q, rp_d, k_q, k_d;
  logic [TCW-1:0] fill_q, fill_d;
  logic           rd_vld_q, rd_vld_d, tap_ok_q, tap_ok_d, prod_vld_q;
  logic           out_valid_q, out_valid_d, load_out, last_tap;
  logic [dfir_pkg::DecWidth-1:0] phase_inc;

  assign phase_inc = dfir_pkg::DecWidth'(phase_q) + dfir_pkg::DecWidth'(1);
  assign last_tap  = (TCW'(k_q) + TCW'(1)) == taps_eff;
  assign load_out  = (state_q == S_SAT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    k_d         = k_q;
    fill_d      = fill_q;
    rd_vld_d    = 1'b0;
    tap_ok_d    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (is_sample) begin
          wp_d   = (wp_q == LastAddr) ? '0 : wp_q + AW'(1);
          fill_d = (fill_q == FillMax) ? fill_q : fill_q + TCW'(1);
          phase_d = (phase_inc >= dec_eff) ? '0 : phase_inc[dfir_pkg::PhaseWidth-1:0];
          if (phase_q == '0) begin
            state_d = S_MAC;
            rp_d    = wp_q;
            k_d     = '0;
          end
        end
      end
      S_MAC: begin
        // tap k reads the sample k steps back from the newest
        rd_vld_d = 1'b1;
        tap_ok_d = TCW'(k_q) < fill_q;
        k_d      = k_q + AW'(1);
        rp_d     = (rp_q == '0) ? LastAddr : rp_q - AW'(1);
        if (last_tap) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      k_q         <= '0;
      fill_q      <= '0;
      rd_vld_q    <= 1'b0;
      tap_ok_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      k_q         <= k_d;
      fill_q      <= fill_d;
      rd_vld_q    <= rd_vld_d;
      tap_ok_q    <= tap_ok_d;
      prod_vld_q  <= rd_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  // memories
  logic [SAMPLE_WIDTH-1:0] samp_rdata;
  logic [COEF_WIDTH-1:0]   coef_rdata;

  dfir_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (is_sample),
    .waddr_i (wp_q),
    .wdata_i (in_i.sample),
    .raddr_i (rp_q),
    .rdata_o (samp_rdata)
  );

  dfir_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (is_coef && coef_in_range),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (in_i.coef_value),
    .raddr_i (k_q),
    .rdata_o (coef_rdata)
  );

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] samp_eff;
  logic signed [COEF_WIDTH-1:0]   coef_s;
  logic signed [PW-1:0]           prod_d, prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [RW-1:0]           round_q, shifted;
  logic signed [SAMPLE_WIDTH-1:0] y_q, y_d;
  logic                           sat_q, sat_d;

  // taps older than the first sample after reset read as zero
  assign samp_eff = tap_ok_q ? signed'(samp_rdata) : '0;
  assign coef_s   = signed'(coef_rdata);
  assign prod_d   = coef_s * samp_eff;
  assign shifted  = round_q >>> (COEF_WIDTH - 1);

  always_comb begin
    priority if (shifted > SatHi) begin
      y_d   = SatHi[SAMPLE_WIDTH-1:0];
      sat_d = 1'b1;
    end else if (shifted < SatLo) begin
      y_d   = SatLo[SAMPLE_WIDTH-1:0];
      sat_d = 1'b1;
    end else begin
      y_d   = shifted[SAMPLE_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (is_sample) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == S_ROUND) begin
      round_q <= RW'(acc_q) + RoundHalf;
    end
    if (load_out) begin
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.filtered  = y_q;
  assign out_o.saturated = sat_q;

`ifndef SYNTHESIS
  a_round_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> !rd_vld_q && !prod_vld_q)
    else $error("rounding started with products still in flight");

  a_out_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SAT))
    else $error("result appeared without passing saturation");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("delay line fill count overran");

  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> TCW'(k_q) < taps_eff)
    else $error("tap index beyond taps in use");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |=> !$past(in_acc))
    else $error("transfer accepted while accumulating");
`endif

endmodule
